/* rtl/fmpacl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes of the first-match prefix access control list.
package fmpacl_pkg;

	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_PATTERN = 3'd1;
	localparam logic [2:0] CMD_COMMIT  = 3'd2;
	localparam logic [2:0] CMD_NAME    = 3'd3;
	localparam logic [2:0] CMD_END     = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DENIED = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	localparam logic KIND_COMMIT  = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [7:0] STAR_BYTE = 8'h2A;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic [5:0] caps;
	} req_item_t;

	typedef struct packed {
		logic       reply_kind;
		logic [1:0] status;
		logic [3:0] rule_slot;
		logic [4:0] rules_held;
	} rsp_item_t;

	typedef struct packed {
		logic commit;
		logic compare;
		logic end_name;
	} bank_ctl_t;

endpackage

/* rtl/fmpacl_req_if.sv */
`timescale 1ns / 1ps
// Request channel carrying commands, pattern bytes and name bytes.
interface fmpacl_req_if;
	logic                  valid;
	logic                  ready;
	fmpacl_pkg::req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* rtl/fmpacl_rsp_if.sv */
`timescale 1ns / 1ps
// Response channel carrying commit replies and verdicts.
interface fmpacl_rsp_if;
	logic                  valid;
	logic                  ready;
	fmpacl_pkg::rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* rtl/first_match_prefix_acl.sv */
`timescale 1ns / 1ps
// Top level of the first-match prefix access control list.
//
// The request channel takes one command per transfer: clear the table, add a
// pattern byte, commit the staged pattern with its capability mask, add a
// tool name byte, or end the name with the tool's capability mask. A commit
// or an end of name gives exactly one transfer on the result channel; the
// other commands give none.
// A name byte holds off the next request while its compare waits for the
// registered read of the pattern memory row at the current name position,
// which holds that byte of every rule. A result is presented in the cycle
// after its request transfer.
// The result sits in an output register; while it waits, requests that give
// no result are still taken, and a request that gives one waits for the
// receiver to take the pending result.
// Reset empties the table and the staged pattern and restarts the name.
// The pattern memory and the rule attributes need no clearing, as no entry
// is read before it is written.
module first_match_prefix_acl #(
	parameter int MAX_RULES     = 16,
	parameter int PATTERN_BYTES = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	fmpacl_req_if.sink    request,
	fmpacl_rsp_if.source  result
);
	import fmpacl_pkg::*;

	localparam int NAME_LIMIT = (PATTERN_BYTES >= 127) ? PATTERN_BYTES + 1 : 127;
	localparam int NLW = $clog2(NAME_LIMIT + 1);
	localparam int LW  = $clog2(PATTERN_BYTES + 1);
	localparam int CW  = $clog2(MAX_RULES + 1);
	localparam int RW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int AW  = $clog2(PATTERN_BYTES);

	logic [CW-1:0]  count_q;
	logic [LW-1:0]  stage_q;
	logic [NLW-1:0] nl_q;
	logic           last_star_q;
	logic           pend_q;
	logic [NLW-1:0] nl_s1;
	logic [7:0]     byte_s1;
	logic           res_valid_q;
	rsp_item_t      res_q;

	logic                      accept;
	logic                      is_clear, is_pat, is_commit, is_name, is_end;
	logic                      gives_result;
	logic                      stage_room, table_room, commit_ok;
	logic                      wr_en, rd_en;
	logic [AW-1:0]             rd_row;
	logic [MAX_RULES-1:0][7:0] row_data;
	bank_ctl_t                 bank_ctl;
	logic                      grant;
	logic [RW-1:0]             grant_idx;

	assign is_clear  = (request.item.command == CMD_CLEAR);
	assign is_pat    = (request.item.command == CMD_PATTERN);
	assign is_commit = (request.item.command == CMD_COMMIT);
	assign is_name   = (request.item.command == CMD_NAME);
	assign is_end    = (request.item.command == CMD_END);

	assign gives_result  = is_commit || is_end;
	assign request.ready = !pend_q && (!res_valid_q || result.ready || !gives_result);
	assign accept        = request.valid && request.ready;

	assign stage_room = (stage_q < LW'(PATTERN_BYTES));
	assign table_room = (count_q < CW'(MAX_RULES));
	assign commit_ok  = (stage_q != '0) && table_room;

	assign wr_en  = accept && is_pat && stage_room && table_room;
	assign rd_en  = accept && is_name;
	assign rd_row = (nl_q < NLW'(PATTERN_BYTES)) ? nl_q[AW-1:0] : '0;

	assign bank_ctl.commit   = accept && is_commit && commit_ok;
	assign bank_ctl.compare  = pend_q;
	assign bank_ctl.end_name = accept && is_end;

	fmpacl_pat_mem #(
		.MAX_RULES     (MAX_RULES),
		.PATTERN_BYTES (PATTERN_BYTES)
	) u_pat_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_row  (stage_q[AW-1:0]),
		.wr_lane (count_q[RW-1:0]),
		.wr_byte (request.item.data_byte),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_data (row_data)
	);

	fmpacl_rule_bank #(
		.MAX_RULES     (MAX_RULES),
		.PATTERN_BYTES (PATTERN_BYTES)
	) u_rule_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (bank_ctl),
		.count        (count_q),
		.commit_idx   (count_q[RW-1:0]),
		.commit_len   (stage_q),
		.commit_mask  (request.item.caps),
		.commit_star  (last_star_q),
		.commit_alive (nl_q == '0),
		.cmp_nl       (nl_s1),
		.cmp_byte     (byte_s1),
		.row_data     (row_data),
		.end_nl       (nl_q),
		.end_caps     (request.item.caps),
		.grant        (grant),
		.grant_idx    (grant_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			stage_q     <= '0;
			nl_q        <= '0;
			last_star_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			pend_q <= rd_en;
			if (accept) begin
				if (is_clear) begin
					count_q <= '0;
					stage_q <= '0;
				end
				if (is_pat && stage_room) begin
					stage_q     <= stage_q + LW'(1);
					last_star_q <= (request.item.data_byte == STAR_BYTE);
				end
				if (is_commit) begin
					stage_q <= '0;
					if (commit_ok) begin
						count_q <= count_q + CW'(1);
					end
				end
				if (is_name && nl_q < NLW'(NAME_LIMIT)) begin
					nl_q <= nl_q + NLW'(1);
				end
				if (is_end) begin
					nl_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			nl_s1   <= nl_q;
			byte_s1 <= request.item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && gives_result) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_commit) begin
			res_q.reply_kind <= KIND_COMMIT;
			if (stage_q == '0) begin
				res_q.status     <= ST_EMPTY;
				res_q.rule_slot  <= '0;
				res_q.rules_held <= 5'(count_q);
			end else if (!table_room) begin
				res_q.status     <= ST_FULL;
				res_q.rule_slot  <= '0;
				res_q.rules_held <= 5'(count_q);
			end else begin
				res_q.status     <= ST_OK;
				res_q.rule_slot  <= 4'(count_q);
				res_q.rules_held <= 5'(count_q + CW'(1));
			end
		end else if (accept && is_end) begin
			res_q.reply_kind <= KIND_VERDICT;
			res_q.status     <= grant ? ST_OK : ST_DENIED;
			res_q.rule_slot  <= grant ? 4'(grant_idx) : 4'd0;
			res_q.rules_held <= 5'(count_q);
		end
	end

	assign result.valid = res_valid_q;
	assign result.item  = res_q;

endmodule

/* rtl/fmpacl_pat_mem.sv */
`timescale 1ns / 1ps
// Pattern memory: one row per byte position, one byte lane per rule slot.
module fmpacl_pat_mem #(
	parameter int MAX_RULES     = 16,
	parameter int PATTERN_BYTES = 63
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [$clog2(PATTERN_BYTES)-1:0]      wr_row,
	input  logic [(MAX_RULES > 1 ? $clog2(MAX_RULES) : 1)-1:0] wr_lane,
	input  logic [7:0]                            wr_byte,
	input  logic                                  rd_en,
	input  logic [$clog2(PATTERN_BYTES)-1:0]      rd_row,
	output logic [MAX_RULES-1:0][7:0]             rd_data
);

	logic [MAX_RULES-1:0][7:0] mem [PATTERN_BYTES];
	logic [MAX_RULES-1:0][7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row][wr_lane] <= wr_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/fmpacl_rule_bank.sv */
`timescale 1ns / 1ps
// Rule attributes, per-rule match tracking and first-match verdict.
module fmpacl_rule_bank #(
	parameter int MAX_RULES     = 16,
	parameter int PATTERN_BYTES = 63
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fmpacl_pkg::bank_ctl_t                 ctl,
	input  logic [$clog2(MAX_RULES+1)-1:0]        count,
	input  logic [(MAX_RULES > 1 ? $clog2(MAX_RULES) : 1)-1:0] commit_idx,
	input  logic [$clog2(PATTERN_BYTES+1)-1:0]    commit_len,
	input  logic [5:0]                            commit_mask,
	input  logic                                  commit_star,
	input  logic                                  commit_alive,
	input  logic [$clog2((PATTERN_BYTES >= 127 ? PATTERN_BYTES+1 : 127)+1)-1:0] cmp_nl,
	input  logic [7:0]                            cmp_byte,
	input  logic [MAX_RULES-1:0][7:0]             row_data,
	input  logic [$clog2((PATTERN_BYTES >= 127 ? PATTERN_BYTES+1 : 127)+1)-1:0] end_nl,
	input  logic [5:0]                            end_caps,
	output logic                                  grant,
	output logic [(MAX_RULES > 1 ? $clog2(MAX_RULES) : 1)-1:0] grant_idx
);
	import fmpacl_pkg::*;

	localparam int NAME_LIMIT = (PATTERN_BYTES >= 127) ? PATTERN_BYTES + 1 : 127;
	localparam int NLW = $clog2(NAME_LIMIT + 1);
	localparam int LW  = $clog2(PATTERN_BYTES + 1);
	localparam int CW  = $clog2(MAX_RULES + 1);
	localparam int RW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

	logic [LW-1:0]        len_q  [MAX_RULES];
	logic [5:0]           mask_q [MAX_RULES];
	logic [MAX_RULES-1:0] star_q;
	logic [MAX_RULES-1:0] alive_q;
	logic [MAX_RULES-1:0] kill;
	logic [MAX_RULES-1:0] fits;

	always_comb begin
		logic [LW-1:0] fixed;
		for (int i = 0; i < MAX_RULES; i++) begin
			fixed   = len_q[i] - LW'(star_q[i]);
			kill[i] = 1'b0;
			if (CW'(i) < count && alive_q[i]) begin
				if (cmp_nl < NLW'(fixed)) begin
					kill[i] = (row_data[i] != cmp_byte);
				end else begin
					kill[i] = !star_q[i];
				end
			end
		end
	end

	always_comb begin
		logic hit;
		for (int i = 0; i < MAX_RULES; i++) begin
			if (star_q[i]) begin
				hit = ((NLW+1)'(end_nl) + (NLW+1)'(1)) >= (NLW+1)'(len_q[i]);
			end else begin
				hit = (end_nl == NLW'(len_q[i]));
			end
			fits[i] = (CW'(i) < count) && alive_q[i] && hit
				&& ((mask_q[i] & end_caps) == end_caps);
		end
	end

	always_comb begin
		grant     = 1'b0;
		grant_idx = '0;
		for (int i = MAX_RULES - 1; i >= 0; i--) begin
			if (fits[i]) begin
				grant     = 1'b1;
				grant_idx = RW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			len_q[commit_idx]  <= commit_len;
			mask_q[commit_idx] <= commit_mask;
			star_q[commit_idx] <= commit_star;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
		end else if (ctl.end_name) begin
			alive_q <= '1;
		end else if (ctl.commit) begin
			alive_q[commit_idx] <= commit_alive;
		end else if (ctl.compare) begin
			alive_q <= alive_q & ~kill;
		end
	end

endmodule

/* rtl/fmpacl_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the access control list and their binding.
module fmpacl_checker #(
	parameter int MAX_RULES = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [2:0] req_command,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_kind,
	input logic [1:0] rsp_status,
	input logic [3:0] rsp_index,
	input logic [4:0] rsp_held
);
	import fmpacl_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_status)
			&& $stable(rsp_index) && $stable(rsp_held))
		else $error("result changed while stalled");

	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !($past(rsp_valid) && !$past(rsp_ready))
			|-> $past(req_valid && req_ready
				&& (req_command == CMD_COMMIT || req_command == CMD_END)))
		else $error("result without a commit or end of name");

	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_kind == KIND_COMMIT && rsp_status != ST_DENIED)
			|| (rsp_kind == KIND_VERDICT
				&& (rsp_status == ST_OK || rsp_status == ST_DENIED)))
		else $error("status does not fit reply kind");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_index == 4'd0)
		else $error("rule slot set on a refusal");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && MAX_RULES <= 16 |-> 32'(rsp_held) <= 32'(MAX_RULES))
		else $error("more rules held than the table has");

endmodule

bind first_match_prefix_acl fmpacl_checker #(
	.MAX_RULES (MAX_RULES)
) u_fmpacl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.req_command (request.item.command),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.rsp_kind    (result.item.reply_kind),
	.rsp_status  (result.item.status),
	.rsp_index   (result.item.rule_slot),
	.rsp_held    (result.item.rules_held)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the first-match prefix access control list.
module tb_top;
	import fmpacl_pkg::*;

	localparam int NUM_RULES     = 16;
	localparam int PAT_BYTES     = 63;
	localparam int NAME_CAP      = 127;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	fmpacl_req_if req_if ();
	fmpacl_rsp_if rsp_if ();

	first_match_prefix_acl uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_if),
		.result  (rsp_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [7:0] pat_mem [NUM_RULES][PAT_BYTES];
	int         pat_len [NUM_RULES];
	logic [5:0] rule_caps [NUM_RULES];
	int         table_rules;
	int         staged_bytes;
	int         name_pos;
	logic [NUM_RULES-1:0] live_rules;

	rsp_item_t expected_replies [$];
	rsp_item_t want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int requests_sent = 0;
	int results_seen  = 0;
	int fail_count    = 0;
	int cycle_count   = 0;

	function automatic bit ends_in_star(input int i);
		return pat_len[i] > 0 && pat_mem[i][pat_len[i] - 1] == STAR_BYTE;
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return 8'("a") + 8'($urandom_range(2));
		end else if (r < 80) begin
			return STAR_BYTE;
		end
		return 8'($urandom);
	endfunction

	task automatic reset_acl_model();
		for (int i = 0; i < NUM_RULES; i++) begin
			pat_len[i] = 0;
			rule_caps[i] = '0;
			for (int k = 0; k < PAT_BYTES; k++) begin
				pat_mem[i][k] = '0;
			end
		end
		table_rules = 0;
		staged_bytes = 0;
		name_pos = 0;
		live_rules = '1;
	endtask

	task automatic apply_acl_request(input req_item_t it);
		rsp_item_t r;
		int fixed;
		bit star;
		bit hit;
		bit found;
		r = '0;
		case (it.command)
			CMD_CLEAR: begin
				table_rules = 0;
				staged_bytes = 0;
			end
			CMD_PATTERN: begin
				if (staged_bytes < PAT_BYTES) begin
					if (table_rules < NUM_RULES) begin
						pat_mem[table_rules][staged_bytes] = it.data_byte;
					end
					staged_bytes++;
				end
			end
			CMD_COMMIT: begin
				r.reply_kind = KIND_COMMIT;
				if (staged_bytes == 0) begin
					r.status = ST_EMPTY;
				end else if (table_rules >= NUM_RULES) begin
					r.status = ST_FULL;
				end else begin
					pat_len[table_rules] = staged_bytes;
					rule_caps[table_rules] = it.caps;
					live_rules[table_rules] = (name_pos == 0);
					r.status = ST_OK;
					r.rule_slot = 4'(table_rules);
					table_rules++;
				end
				staged_bytes = 0;
				r.rules_held = 5'(table_rules);
				expected_replies.push_back(r);
			end
			CMD_NAME: begin
				for (int i = 0; i < table_rules; i++) begin
					if (live_rules[i]) begin
						star = ends_in_star(i);
						fixed = star ? pat_len[i] - 1 : pat_len[i];
						if (name_pos < fixed) begin
							if (pat_mem[i][name_pos] != it.data_byte) begin
								live_rules[i] = 1'b0;
							end
						end else if (!star) begin
							live_rules[i] = 1'b0;
						end
					end
				end
				if (name_pos < NAME_CAP) begin
					name_pos++;
				end
			end
			CMD_END: begin
				r.reply_kind = KIND_VERDICT;
				r.status = ST_DENIED;
				found = 1'b0;
				for (int i = 0; i < table_rules; i++) begin
					if (!found && live_rules[i]) begin
						if (ends_in_star(i)) begin
							hit = name_pos + 1 >= pat_len[i];
						end else begin
							hit = name_pos == pat_len[i];
						end
						if (hit && (rule_caps[i] & it.caps) == it.caps) begin
							found = 1'b1;
							r.status = ST_OK;
							r.rule_slot = 4'(i);
						end
					end
				end
				live_rules = '1;
				name_pos = 0;
				r.rules_held = 5'(table_rules);
				expected_replies.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
			input logic [5:0] mask);
		req_item_t it;
		it.command = cmd;
		it.data_byte = data;
		it.caps = mask;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.item <= it;
		req_if.valid <= 1'b1;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		apply_acl_request(it);
		requests_sent++;
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_replies.size() != 0);
	endtask

	task automatic test_basic_rules();
		send_item(CMD_COMMIT, 8'h00, 6'h3F);
		send_item(CMD_END, 8'h00, 6'h00);
		send_item(CMD_PATTERN, 8'h00, 6'h00);
		send_item(CMD_PATTERN, 8'hFF, 6'h3F);
		send_item(CMD_COMMIT, 8'h00, 6'h01);
		send_item(CMD_PATTERN, "a", 6'h00);
		send_item(CMD_PATTERN, STAR_BYTE, 6'h00);
		send_item(CMD_COMMIT, 8'hFF, 6'h3E);
		send_item(CMD_NAME, 8'h00, 6'h00);
		send_item(CMD_NAME, 8'hFF, 6'h00);
		send_item(CMD_END, 8'h00, 6'h01);
		send_item(CMD_NAME, 8'h00, 6'h00);
		send_item(CMD_NAME, 8'hFF, 6'h00);
		send_item(CMD_END, 8'h00, 6'h02);
		send_item(CMD_NAME, "a", 6'h00);
		send_item(CMD_END, 8'h00, 6'h3E);
		send_item(CMD_PATTERN, STAR_BYTE, 6'h00);
		send_item(CMD_COMMIT, 8'h00, 6'h3F);
		send_item(CMD_NAME, "x", 6'h00);
		send_item(CMD_PATTERN, "x", 6'h00);
		send_item(CMD_COMMIT, 8'h00, 6'h3F);
		send_item(CMD_END, 8'h00, 6'h3F);
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
			send_item(3'(c), 8'hFF, 6'h3F);
		end
		send_item(CMD_CLEAR, 8'h00, 6'h00);
		send_item(CMD_END, 8'h00, 6'h00);
	endtask

	task automatic test_table_full();
		send_item(CMD_CLEAR, 8'($urandom), 6'($urandom));
		for (int k = 0; k < NUM_RULES; k++) begin
			send_item(CMD_PATTERN, "r", 6'h00);
			send_item(CMD_PATTERN, 8'(k), 6'h00);
			send_item(CMD_COMMIT, 8'h00, 6'($urandom));
		end
		for (int k = 0; k < 3; k++) begin
			send_item(CMD_PATTERN, pick_byte(), 6'h00);
		end
		send_item(CMD_COMMIT, 8'h00, 6'h3F);
		send_item(CMD_COMMIT, 8'h00, 6'h3F);
		send_item(CMD_NAME, "r", 6'h00);
		send_item(CMD_NAME, 8'd5, 6'h00);
		send_item(CMD_END, 8'h00, 6'h00);
	endtask

	task automatic test_long_inputs();
		send_item(CMD_CLEAR, 8'h00, 6'h00);
		for (int k = 0; k < PAT_BYTES; k++) begin
			send_item(CMD_PATTERN, "q", 6'h00);
		end
		send_item(CMD_PATTERN, STAR_BYTE, 6'h00);
		send_item(CMD_PATTERN, STAR_BYTE, 6'h00);
		send_item(CMD_COMMIT, 8'h00, 6'h3F);
		send_item(CMD_PATTERN, STAR_BYTE, 6'h00);
		send_item(CMD_COMMIT, 8'h00, 6'h01);
		for (int k = 0; k <= PAT_BYTES; k++) begin
			send_item(CMD_NAME, "q", 6'h00);
		end
		send_item(CMD_END, 8'h00, 6'h3F);
		for (int k = 0; k < PAT_BYTES; k++) begin
			send_item(CMD_NAME, "q", 6'h00);
		end
		send_item(CMD_END, 8'h00, 6'h3F);
		for (int k = 0; k < NAME_CAP + 13; k++) begin
			send_item(CMD_NAME, "q", 6'h00);
		end
		send_item(CMD_END, 8'h00, 6'h01);
		for (int k = 0; k < NAME_CAP + 13; k++) begin
			send_item(CMD_NAME, "q", 6'h00);
		end
		send_item(CMD_END, 8'h00, 6'h3F);
	endtask

	task automatic test_result_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		for (int k = 0; k < 48; k++) begin
			if (k % 3 == 0) begin
				send_item(CMD_NAME, pick_byte(), 6'($urandom));
			end else begin
				send_item(CMD_END, 8'($urandom), 6'($urandom));
			end
		end
		wait_drained();
	endtask

	task automatic test_random_traffic(input int item_goal, input int src_pct,
			input int dst_pct);
		int first;
		int choice;
		int r;
		int len;
		int fixed;
		int mode;
		int spot;
		bit star;
		logic [7:0] b;
		logic [5:0] m;
		send_idle_pct = src_pct;
		recv_idle_pct = dst_pct;
		first = requests_sent;
		while (requests_sent - first < item_goal) begin
			choice = $urandom_range(99);
			if (choice < 4 || (table_rules == NUM_RULES && choice < 12)) begin
				send_item(CMD_CLEAR, 8'($urandom), 6'($urandom));
			end else if (choice < 34) begin
				r = $urandom_range(99);
				len = (r < 5) ? 0 : (r < 10) ? $urandom_range(PAT_BYTES + 4, 7)
					: $urandom_range(6, 1);
				star = ($urandom_range(99) < 40);
				for (int k = 0; k < len; k++) begin
					b = (star && k == len - 1) ? STAR_BYTE : pick_byte();
					send_item(CMD_PATTERN, b, 6'($urandom));
				end
				m = $urandom_range(1) ? 6'h3F : 6'($urandom);
				send_item(CMD_COMMIT, 8'($urandom), m);
			end else if (choice < 94) begin
				if (table_rules > 0 && $urandom_range(99) < 75) begin
					r = $urandom_range(table_rules - 1);
					fixed = ends_in_star(r) ? pat_len[r] - 1 : pat_len[r];
					mode = $urandom_range(3);
					if (mode == 1) begin
						len = fixed + $urandom_range(4, 1);
					end else if (mode == 3 && fixed > 0) begin
						len = fixed - 1;
					end else begin
						len = fixed;
					end
					spot = (mode == 2 && fixed > 0) ? $urandom_range(fixed - 1) : -1;
					for (int k = 0; k < len; k++) begin
						b = (k < fixed) ? pat_mem[r][k] : pick_byte();
						if (k == spot) begin
							b = b ^ 8'($urandom_range(255, 1));
						end
						send_item(CMD_NAME, b, 6'($urandom));
					end
					m = ($urandom_range(99) < 60) ? (rule_caps[r] & 6'($urandom))
						: 6'($urandom);
				end else begin
					len = $urandom_range(6);
					for (int k = 0; k < len; k++) begin
						send_item(CMD_NAME, pick_byte(), 6'($urandom));
					end
					m = 6'($urandom);
				end
				send_item(CMD_END, 8'($urandom), m);
			end else begin
				send_item(3'($urandom), 8'($urandom), 6'($urandom));
			end
		end
	endtask

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			results_seen++;
			if (expected_replies.size() == 0) begin
				$error("result transfer with nothing expected: %p", rsp_if.item);
				fail_count++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_if.item.reply_kind !== want.reply_kind) begin
					$error("reply_kind: expected %0d, got %0d", want.reply_kind,
						rsp_if.item.reply_kind);
					fail_count++;
				end
				if (rsp_if.item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status,
						rsp_if.item.status);
					fail_count++;
				end
				if (rsp_if.item.rule_slot !== want.rule_slot) begin
					$error("rule_slot: expected %0d, got %0d", want.rule_slot,
						rsp_if.item.rule_slot);
					fail_count++;
				end
				if (rsp_if.item.rules_held !== want.rules_held) begin
					$error("rules_held: expected %0d, got %0d", want.rules_held,
						rsp_if.item.rules_held);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("first_match_prefix_acl: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.item = '0;
		reset_acl_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_rules();
		test_table_full();
		test_long_inputs();
		wait_drained();
		test_result_stall();
		test_random_traffic(380, 33, 47);
		wait_drained();
		test_random_traffic(380, 47, 33);
		wait_drained();
		test_random_traffic(180, 0, 0);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests and checked %0d results in %0d cycles.",
			requests_sent, results_seen, cycle_count);
		$display("Covered rule loading, full and cleared tables, long inputs and stalls.");
		if (fail_count == 0) begin
			$display("first_match_prefix_acl: match");
		end else begin
			$display("first_match_prefix_acl: mismatch");
		end
		$finish;
	end
endmodule
